/* rtl/utat_pkg.sv */
`default_nettype none

package utat_pkg;

    localparam logic [6:0] CH_UNKNOWN = 7'h3F;
    localparam logic [6:0] CH_TERM    = 7'h00;

    typedef enum logic [2:0] {
        BC_ASCII,
        BC_LEAD2,
        BC_LEAD3,
        BC_LEAD4,
        BC_CONT,
        BC_BAD
    } byte_class_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } res_t;

    // one queue entry: the one or two results caused by one input beat
    typedef struct packed {
        res_t first;
        res_t second;
        logic two;
    } entry_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (!b[7])
            c = BC_ASCII;
        else if (b[7:5] == 3'b110)
            c = BC_LEAD2;
        else if (b[7:4] == 4'b1110)
            c = BC_LEAD3;
        else if (b[7:3] == 5'b11110)
            c = BC_LEAD4;
        else if (b[7:6] == 2'b10)
            c = BC_CONT;
        else
            c = BC_BAD;
        return c;
    endfunction

    // cp is the low byte of a code point in A0..FF
    function automatic logic [6:0] latin1_base(input logic [7:0] cp);
        logic [6:0] ch;
        if (cp == 8'hA1)                      ch = 7'h21; // !
        else if (cp == 8'hBF)                 ch = 7'h3F; // ?
        else if (cp >= 8'hC0 && cp <= 8'hC5)  ch = 7'h41; // A
        else if (cp == 8'hC7)                 ch = 7'h43; // C
        else if (cp >= 8'hC8 && cp <= 8'hCB)  ch = 7'h45; // E
        else if (cp >= 8'hCC && cp <= 8'hCF)  ch = 7'h49; // I
        else if (cp == 8'hD0)                 ch = 7'h44; // D
        else if (cp == 8'hD1)                 ch = 7'h4E; // N
        else if (cp >= 8'hD2 && cp <= 8'hD6)  ch = 7'h4F; // O
        else if (cp >= 8'hD8 && cp <= 8'hDD)  ch = 7'h55; // U
        else if (cp >= 8'hE0 && cp <= 8'hE5)  ch = 7'h61; // a
        else if (cp == 8'hE7)                 ch = 7'h63; // c
        else if (cp >= 8'hE8 && cp <= 8'hEB)  ch = 7'h65; // e
        else if (cp >= 8'hEC && cp <= 8'hEF)  ch = 7'h69; // i
        else if (cp == 8'hF0)                 ch = 7'h64; // d
        else if (cp == 8'hF1)                 ch = 7'h6E; // n
        else if (cp >= 8'hF2 && cp <= 8'hF6)  ch = 7'h6F; // o
        else if (cp >= 8'hF8 && cp <= 8'hFD)  ch = 7'h75; // u
        else if (cp == 8'hFF)                 ch = 7'h79; // y
        else                                  ch = CH_UNKNOWN;
        return ch;
    endfunction

endpackage

`default_nettype wire

/* rtl/utat_in_if.sv */
`default_nettype none

interface utat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_mark;

    modport source (output valid, output in_byte, output end_mark, input ready);
    modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

`default_nettype wire

/* rtl/utat_out_if.sv */
`default_nettype none

interface utat_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

/* rtl/utat_front.sv */
`default_nettype none

module utat_front
    import utat_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    utat_in_if.sink     in_ch,
    output logic        push,
    output entry_t      push_data,
    input  wire logic   full
);

    logic        lead_held_reg, lead_held_next;
    logic [4:0]  lead_bits_reg, lead_bits_next;
    logic [1:0]  skip_reg, skip_next;

    logic        accept;
    byte_class_t cls;
    logic        fr_emit;
    logic [6:0]  fr_char;
    logic        fr_hold;
    logic [1:0]  fr_skip;
    logic        in_range;
    logic [6:0]  pair_char;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cls         = classify(in_ch.in_byte);

    // two-byte points A0..FF: lead 2 with cont bit 5 set, or lead 3
    assign in_range  = (lead_bits_reg == 5'd3) ||
                       ((lead_bits_reg == 5'd2) && in_ch.in_byte[5]);
    assign pair_char = in_range ? latin1_base({lead_bits_reg[1:0], in_ch.in_byte[5:0]})
                                : CH_UNKNOWN;

    // handling of a byte with nothing held and no skip pending
    always_comb
    begin
        fr_emit = 1'b1;
        fr_char = CH_UNKNOWN;
        fr_hold = 1'b0;
        fr_skip = 2'd0;
        unique case (cls)
            BC_ASCII: fr_char = in_ch.in_byte[6:0];
            BC_LEAD2:
            begin
                fr_emit = 1'b0;
                fr_hold = 1'b1;
            end
            BC_LEAD3: fr_skip = 2'd2;
            BC_LEAD4: fr_skip = 2'd3;
            BC_CONT,
            BC_BAD:   fr_char = CH_UNKNOWN;
        endcase
    end

    always_comb
    begin
        lead_held_next   = lead_held_reg;
        lead_bits_next   = lead_bits_reg;
        skip_next        = skip_reg;
        push             = 1'b0;
        push_data.first  = '{out_char: CH_UNKNOWN, out_last: 1'b0};
        push_data.second = '{out_char: CH_TERM, out_last: 1'b1};
        push_data.two    = 1'b0;
        if (accept)
        begin
            priority if (in_ch.end_mark)
            begin
                lead_held_next = 1'b0;
                lead_bits_next = 5'd0;
                skip_next      = 2'd0;
                push           = 1'b1;
                if (lead_held_reg)
                    push_data.two = 1'b1;
                else
                    push_data.first = '{out_char: CH_TERM, out_last: 1'b1};
            end
            else if (skip_reg != 2'd0)
            begin
                skip_next = skip_reg - 2'd1;
            end
            else if (lead_held_reg && cls == BC_CONT)
            begin
                lead_held_next  = 1'b0;
                lead_bits_next  = 5'd0;
                push            = 1'b1;
                push_data.first = '{out_char: pair_char, out_last: 1'b0};
            end
            else
            begin
                lead_held_next = fr_hold;
                lead_bits_next = fr_hold ? in_ch.in_byte[4:0] : 5'd0;
                skip_next      = fr_skip;
                if (lead_held_reg)
                begin
                    // broken pair: '?' then the byte taken afresh
                    push             = 1'b1;
                    push_data.two    = fr_emit;
                    push_data.second = '{out_char: fr_char, out_last: 1'b0};
                end
                else
                begin
                    push            = fr_emit;
                    push_data.first = '{out_char: fr_char, out_last: 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_held_reg <= 1'b0;
            lead_bits_reg <= 5'd0;
            skip_reg      <= 2'd0;
        end
        else
        begin
            lead_held_reg <= lead_held_next;
            lead_bits_reg <= lead_bits_next;
            skip_reg      <= skip_next;
        end
    end

    a_hold_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(lead_held_reg && skip_reg != 2'd0))
        else $error("lead held while skipping");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.end_mark) |=> (!lead_held_reg && skip_reg == 2'd0))
        else $error("end marker left state behind");

endmodule

`default_nettype wire

/* rtl/utat_queue.sv */
`default_nettype none

module utat_queue
    import utat_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output entry_t      pop_data,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/utat_back.sv */
`default_nettype none

module utat_back
    import utat_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    output logic        pop,
    input  wire entry_t pop_data,
    input  wire logic   empty,
    utat_out_if.source  out_ch
);

    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg, out_res_next;
    logic       sec_pend_reg, sec_pend_next;
    res_t       sec_reg, sec_next;
    logic       load_ok;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_char = out_res_reg.out_char;
    assign out_ch.out_last = out_res_reg.out_last;

    assign load_ok = !out_valid_reg || out_ch.ready;
    assign pop     = load_ok && !sec_pend_reg && !empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        sec_pend_next  = sec_pend_reg;
        sec_next       = sec_reg;
        if (load_ok)
        begin
            priority if (sec_pend_reg)
            begin
                out_valid_next = 1'b1;
                out_res_next   = sec_reg;
                sec_pend_next  = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next = 1'b1;
                out_res_next   = pop_data.first;
                sec_pend_next  = pop_data.two;
                sec_next       = pop_data.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        sec_reg     <= sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_pend_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_pend_reg  <= sec_pend_next;
        end
    end

    a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        sec_pend_reg |-> out_valid_reg)
        else $error("second result pending with no first on output");

endmodule

`default_nettype wire

/* rtl/utf8_to_ascii_transliterator.sv */
// UTF-8 to ASCII transliterator.
// in_ch carries one beat per UTF-8 byte (in_byte) or an end marker (end_mark=1).
// out_ch carries ASCII characters (out_char); out_last=1 marks the terminator
// beat (out_char 0) that closes a string.
// Throughput: one input beat per cycle while the queue is not full. Each beat
// gives zero, one or two results; the output drains one result per cycle while
// out_ch is ready, so a beat with two results (broken pair, end marker after a
// held lead) sends them one after the other. The accepting edge writes the
// queue, and the output register is loaded from the queue once it is free, so
// a beat's first result reaches out_ch through both; a second result follows.
// The front end decodes and writes results to a QUEUE_DEPTH-entry queue; in_ch
// ready drops only while that queue is full. The back end keeps one output
// register, so a stalled receiver holds out_ch steady and input continues to
// be taken until the queue fills.
// Reset clears any held lead and skip count and empties the queue; no
// clearing pass is needed, in_ch is ready as soon as reset is released.
`default_nettype none

module utf8_to_ascii_transliterator
    import utat_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    utat_in_if.sink     in_ch,
    utat_out_if.source  out_ch
);

    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    entry_t pop_data;
    logic   empty;

    utat_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    utat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    utat_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

import utat_pkg::*;

// Tracks decoder state and keeps the characters still due on the output.
class ascii_predictor;
    res_t       pending_chars[$];
    logic [4:0] lead_bits;
    bit         lead_waiting;
    logic [1:0] skip_left;
    int         mismatches;

    function new();
        lead_bits    = '0;
        lead_waiting = 1'b0;
        skip_left    = '0;
        mismatches   = 0;
    endfunction

    function int outstanding();
        return pending_chars.size();
    endfunction

    function void push_char(logic [7:0] c, logic last);
        res_t r;
        r.out_char = c[6:0];
        r.out_last = last;
        pending_chars.push_back(r);
    endfunction

    // base letter for a Latin-1 point in A0..FF
    function logic [7:0] accent_base(logic [7:0] cp);
        logic [7:0] c;
        case (cp)
            8'hA1:                                      c = "!";
            8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5:  c = "A";
            8'hC7:                                      c = "C";
            8'hC8, 8'hC9, 8'hCA, 8'hCB:                 c = "E";
            8'hCC, 8'hCD, 8'hCE, 8'hCF:                 c = "I";
            8'hD0:                                      c = "D";
            8'hD1:                                      c = "N";
            8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6:         c = "O";
            8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD:  c = "U";
            8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5:  c = "a";
            8'hE7:                                      c = "c";
            8'hE8, 8'hE9, 8'hEA, 8'hEB:                 c = "e";
            8'hEC, 8'hED, 8'hEE, 8'hEF:                 c = "i";
            8'hF0:                                      c = "d";
            8'hF1:                                      c = "n";
            8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6:         c = "o";
            8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD:  c = "u";
            8'hFF:                                      c = "y";
            default:                                    c = {1'b0, CH_UNKNOWN};
        endcase
        return c;
    endfunction

    function void note_beat(logic [7:0] b, logic end_mark);
        logic [10:0] cp;
        if (end_mark)
        begin
            if (lead_waiting)
                push_char({1'b0, CH_UNKNOWN}, 1'b0);
            lead_waiting = 1'b0;
            lead_bits    = '0;
            skip_left    = '0;
            push_char({1'b0, CH_TERM}, 1'b1);
            return;
        end
        if (skip_left != 0)
        begin
            skip_left = skip_left - 2'd1;
            return;
        end
        if (lead_waiting)
        begin
            lead_waiting = 1'b0;
            if (b[7:6] == 2'b10)
            begin
                cp        = {lead_bits, b[5:0]};
                lead_bits = '0;
                if (cp >= 11'h0A0 && cp <= 11'h0FF)
                    push_char(accent_base(cp[7:0]), 1'b0);
                else
                    push_char({1'b0, CH_UNKNOWN}, 1'b0);
                return;
            end
            // broken pair: flag it, then treat the byte as new
            lead_bits = '0;
            push_char({1'b0, CH_UNKNOWN}, 1'b0);
        end
        if (!b[7])
        begin
            push_char(b, 1'b0);
        end
        else if (b[7:5] == 3'b110)
        begin
            lead_bits    = b[4:0];
            lead_waiting = 1'b1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            skip_left = 2'd2;
            push_char({1'b0, CH_UNKNOWN}, 1'b0);
        end
        else if (b[7:3] == 5'b11110)
        begin
            skip_left = 2'd3;
            push_char({1'b0, CH_UNKNOWN}, 1'b0);
        end
        else
        begin
            push_char({1'b0, CH_UNKNOWN}, 1'b0);
        end
    endfunction

    function void check_char(logic [6:0] c, logic last);
        res_t want;
        if (pending_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected beat out_char=%h out_last=%b", c, last);
            return;
        end
        want = pending_chars.pop_front();
        if (want.out_char !== c || want.out_last !== last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: out_char exp %h got %h, out_last exp %b got %b",
                         want.out_char, c, want.out_last, last);
        end
    endfunction
endclass

module testbench;
    localparam logic [8:0] END_BEAT = 9'h100;

    logic clk;
    logic rst_n;
    int   burst_left;
    int   beats_sent;

    utat_in_if  in_ch();
    utat_out_if out_ch();

    ascii_predictor expected;

    utf8_to_ascii_transliterator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("** utf8_to_ascii_transliterator: FAILED **");
        $finish;
    end

    // sender works in bursts; call only right after posedge clk
    task automatic send_beat(input logic [7:0] b, input logic end_mark);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.end_mark <= end_mark;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        expected.note_beat(b, end_mark);
        beats_sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // receiver: checks each accepted beat and drives ready in a random stall mode
    initial
    begin
        int cyc;
        int rx_mode;
        int hold;
        out_ch.ready = 1'b0;
        cyc     = 0;
        rx_mode = 0;
        hold    = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                expected.check_char(out_ch.out_char, out_ch.out_last);
            cyc++;
            if (cyc % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (hold == 0)
                        hold = $urandom_range(2, 30);
                    hold--;
                    out_ch.ready <= (hold == 0);
                end
            endcase
        end
    end

    initial
    begin
        logic [8:0] directed[$];
        logic [7:0] b;
        int         pick;
        int         k;
        int         n_cont;
        bit         drained;

        expected       = new();
        burst_left     = 0;
        beats_sent     = 0;
        drained        = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.end_mark = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ascii extremes, accented letter, A0, point above FF, overlong lead,
        // broken pair, skip over NUL/ascii, 4-byte skip, stray bytes,
        // end with held lead, end during skip
        directed = '{9'h041, 9'h07F, 9'h000, 9'h0C3, 9'h0A9, 9'h0C2, 9'h0A0,
                     9'h0DF, 9'h0BF, 9'h0C0, 9'h080, 9'h0C3, 9'h041, 9'h0E2,
                     9'h000, 9'h041, 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h080,
                     9'h0FF, 9'h0C3, END_BEAT, 9'h0E2, END_BEAT};
        foreach (directed[i])
            send_beat(directed[i][7:0], directed[i][8]);

        while (beats_sent < 700)
        begin
            if (!drained && beats_sent >= 350)
            begin
                // hold off until the output side has caught up
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (expected.outstanding() != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_beat(8'($urandom_range(0, 127)), 1'b0);
            end
            else if (pick < 60)
            begin
                b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hC2, 8'hC3))
                                                : 8'($urandom_range(8'hC0, 8'hDF));
                send_beat(b, 1'b0);
                send_beat(cont_byte(), 1'b0);
            end
            else if (pick < 74)
            begin
                n_cont = (pick < 68) ? 2 : 3;
                b = (n_cont == 2) ? 8'($urandom_range(8'hE0, 8'hEF))
                                  : 8'($urandom_range(8'hF0, 8'hF7));
                send_beat(b, 1'b0);
                for (k = 0; k < n_cont; k++)
                    send_beat(cont_byte(), 1'b0);
            end
            else if (pick < 82)
            begin
                // lead followed by anything but a continuation byte
                send_beat(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
                k = $urandom_range(0, 191);
                if (k >= 128)
                    k += 64;
                send_beat(8'(k), 1'b0);
            end
            else if (pick < 88)
            begin
                // long sequence cut short
                send_beat(8'($urandom_range(8'hE0, 8'hF7)), 1'b0);
                n_cont = $urandom_range(0, 1);
                for (k = 0; k < n_cont; k++)
                    send_beat(cont_byte(), 1'b0);
            end
            else if (pick < 95)
            begin
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        end

        in_ch.valid <= 1'b0;
        while (expected.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected.mismatches == 0 && expected.outstanding() == 0)
            $display("** utf8_to_ascii_transliterator: PASSED **");
        else
            $display("** utf8_to_ascii_transliterator: FAILED **");
        $finish;
    end
endmodule
